// File: hw/rtl/gbs_pkg.sv
package gbs_pkg;

    localparam int ROWS_MAX     = 64;
    localparam int COLS_MAX     = 64;
    localparam int ENERGIES_MAX = 4;
    localparam int COMPS_MAX    = 2 * ENERGIES_MAX;

    localparam int ROW_W  = $clog2(ROWS_MAX);
    localparam int COL_W  = $clog2(COLS_MAX);
    localparam int COMP_W = $clog2(COMPS_MAX);
    localparam int IDX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int ADDR_W = ROW_W + COL_W + COMP_W;
    localparam int DEPTH  = ROWS_MAX * COLS_MAX * COMPS_MAX;

    localparam int VAL_W      = 32;
    localparam int STEP_W     = 31;
    localparam int CNT_W      = 7;
    localparam int EN_W       = 3;
    localparam int CFG_ADDR_W = 3;

    // wide datapath of the blend and the rounding divide
    localparam int ACC_W  = 96;
    localparam int DIVD_W = ACC_W + 1;
    localparam int DIVS_W = 64;
    localparam int QUO_W  = 33;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROWS     = 3'd0,
        REG_COLS     = 3'd1,
        REG_ENERGIES = 3'd2,
        REG_Z_START  = 3'd3,
        REG_Z_STEP   = 3'd4,
        REG_X_START  = 3'd5,
        REG_X_STEP   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic              outside;
        logic [IDX_W-1:0]  idx;
        logic [STEP_W-1:0] rem;
    } coord_res_t;

endpackage

// File: hw/rtl/gbs_ram.sv
module gbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/gbs_coord_div.sv
module gbs_coord_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [32:0]                  offset,
    input  logic [gbs_pkg::STEP_W-1:0]   step,
    input  logic [gbs_pkg::CNT_W-1:0]    limit,
    output logic                         done,
    output gbs_pkg::coord_res_t          res
);
    import gbs_pkg::*;

    localparam int NUM_W = 32;
    localparam int SC_W  = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [SC_W-1:0]  cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic             neg_reg;
    logic [NUM_W-1:0] rem_sh;
    logic             fits;

    // one quotient bit per cycle
    assign rem_sh = {rem_reg[NUM_W-2:0], num_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, step};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SC_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SC_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= offset[32];
            num_reg <= offset[NUM_W-1:0];
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? rem_sh - {1'b0, step} : rem_sh;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done        = done_reg;
    assign res.outside = neg_reg || (({1'b0, quo_reg} + 33'd1) >= {26'd0, limit});
    assign res.idx     = quo_reg[IDX_W-1:0];
    assign res.rem     = rem_reg[STEP_W-1:0];
endmodule

// File: hw/rtl/gbs_wide_div.sv
module gbs_wide_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gbs_pkg::DIVD_W-1:0]  dividend,
    input  logic [gbs_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [gbs_pkg::QUO_W-1:0]   quo,
    output logic                        big
);
    import gbs_pkg::*;

    localparam int SC_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [SC_W-1:0]   cnt_reg;
    logic [DIVD_W-1:0] num_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              big_reg;
    logic [DIVS_W-1:0] rem_sh;
    logic              fits;

    // remainder stays below a divisor under 2^63, so the shift cannot overflow
    assign rem_sh = {rem_reg[DIVS_W-2:0], num_reg[DIVD_W-1]};
    assign fits   = rem_sh >= divisor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SC_W'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SC_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
            big_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= fits ? rem_sh - divisor : rem_sh;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            // any bit pushed past the top means the quotient saturates
            big_reg <= big_reg | quo_reg[QUO_W-1];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign big  = big_reg;
endmodule

// File: hw/rtl/grid_bilinear_sampler.sv
// sequence: a grid write is stored as it is accepted; a sample first runs the coordinate divides,
// then for each of the 2*energies components four reads, eight multiplies, the rounding divide
// and one result beat, which waits for m_ready; outside the grid, one zero beat per component
// throughput: one item at a time; the serial divider and the single ram read port set the rate
// reset: aresetn synchronous active low clears control state and loads register defaults;
// grid contents are undefined until written
module grid_bilinear_sampler (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [gbs_pkg::ROW_W-1:0]          s_row_index,
    input  logic [gbs_pkg::COL_W-1:0]          s_col_index,
    input  logic [gbs_pkg::COMP_W-1:0]         s_component_index,
    input  logic signed [gbs_pkg::VAL_W-1:0]   s_sample_value,
    input  logic signed [gbs_pkg::VAL_W-1:0]   s_z_coord,
    input  logic signed [gbs_pkg::VAL_W-1:0]   s_x_coord,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gbs_pkg::COMP_W-1:0]         m_out_component,
    output logic signed [gbs_pkg::VAL_W-1:0]   m_out_value,
    output logic                               m_last_of_run,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gbs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gbs_pkg::VAL_W-1:0]          cfg_data
);
    import gbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CDIV, ST_READ, ST_WAITRD, ST_MUL, ST_SUM,
        ST_MUL2, ST_MAG, ST_DSTART, ST_DIV, ST_EMIT
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0]  rows_reg, cols_reg;
    logic [EN_W-1:0]   en_reg;
    logic [VAL_W-1:0]  zs_reg, xs_reg;
    logic [STEP_W-1:0] zstep_reg, xstep_reg;

    logic [CNT_W-1:0]  nz, nx;
    logic [EN_W-1:0]   en_eff;
    logic [STEP_W-1:0] dz, dx, wz0, wx0;
    logic [COMP_W-1:0] last_comp;

    logic              in_acc, is_sample;
    logic [32:0]       offz, offx;
    logic              cz_done, cx_done;
    coord_res_t        cz, cx;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic [COMP_W-1:0] comp_reg;
    logic [1:0]        rd_cnt_reg, cap_idx_reg;
    logic              cap_vld_reg;
    logic [VAL_W-1:0]  f_reg [4];
    logic [2:0]        mul_cnt_reg;
    logic [63:0]       p_reg [4];
    logic [63:0]       lower_reg, upper_reg;
    logic [65:0]       pp_reg;
    logic              pp_hi_reg;
    logic [ACC_W-1:0]  acc_reg, mag_reg, pp_ext;
    logic              neg_reg;
    logic [61:0]       denom_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic              div_start, div_done, div_big;
    logic [DIVD_W-1:0] div_dividend;
    logic [QUO_W-1:0]  div_quo;
    logic [VAL_W-1:0]  sat_val;

    logic              m_valid_reg, m_last_reg;
    logic [VAL_W-1:0]  m_value_reg;

    // effective register values
    assign nz        = (rows_reg > CNT_W'(ROWS_MAX)) ? CNT_W'(ROWS_MAX) : rows_reg;
    assign nx        = (cols_reg > CNT_W'(COLS_MAX)) ? CNT_W'(COLS_MAX) : cols_reg;
    assign en_eff    = (en_reg == '0) ? EN_W'(1)
                     : ((en_reg > EN_W'(ENERGIES_MAX)) ? EN_W'(ENERGIES_MAX) : en_reg);
    assign last_comp = COMP_W'({en_eff, 1'b0} - 1'b1);
    assign dz        = (zstep_reg == '0) ? STEP_W'(1) : zstep_reg;
    assign dx        = (xstep_reg == '0) ? STEP_W'(1) : xstep_reg;
    assign wz0       = dz - cz.rem;
    assign wx0       = dx - cx.rem;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign is_sample = in_acc && s_mode;

    assign offz = {s_z_coord[VAL_W-1], s_z_coord} - {zs_reg[VAL_W-1], zs_reg};
    assign offx = {s_x_coord[VAL_W-1], s_x_coord} - {xs_reg[VAL_W-1], xs_reg};

    gbs_coord_div u_zdiv (
        .aclk(aclk), .aresetn(aresetn), .start(is_sample), .offset(offz),
        .step(dz), .limit(nz), .done(cz_done), .res(cz)
    );

    gbs_coord_div u_xdiv (
        .aclk(aclk), .aresetn(aresetn), .start(is_sample), .offset(offx),
        .step(dx), .limit(nx), .done(cx_done), .res(cx)
    );

    assign ram_we    = in_acc && !s_mode && (32'(s_component_index) < 32'(COMPS_MAX));
    assign ram_waddr = {s_row_index, s_col_index, s_component_index};
    // corners in order: lower-left, lower-right, upper-left, upper-right
    assign ram_raddr = {cz.idx[ROW_W-1:0] + ROW_W'(rd_cnt_reg[1]),
                        cx.idx[COL_W-1:0] + COL_W'(rd_cnt_reg[0]), comp_reg};

    gbs_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_grid (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(s_sample_value),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CDIV: begin
                mul_a = {2'b00, dz};
                mul_b = {2'b00, dx};
            end
            ST_MUL: begin
                mul_a = {f_reg[mul_cnt_reg[1:0]][VAL_W-1], f_reg[mul_cnt_reg[1:0]]};
                mul_b = {2'b00, mul_cnt_reg[0] ? cx.rem : wx0};
            end
            ST_MUL2: begin
                case (mul_cnt_reg)
                    3'd0:    mul_a = {1'b0, lower_reg[31:0]};
                    3'd1:    mul_a = {lower_reg[63], lower_reg[63:32]};
                    3'd2:    mul_a = {1'b0, upper_reg[31:0]};
                    default: mul_a = {upper_reg[63], upper_reg[63:32]};
                endcase
                mul_b = {2'b00, mul_cnt_reg[1] ? cz.rem : wz0};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign pp_ext = {{(ACC_W-66){pp_reg[65]}}, pp_reg};

    assign div_start    = (state_reg == ST_DSTART);
    assign div_dividend = {mag_reg, 1'b0} + {{(DIVD_W-62){1'b0}}, denom_reg};

    gbs_wide_div u_rdiv (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor({1'b0, denom_reg, 1'b0}), .done(div_done), .quo(div_quo), .big(div_big)
    );

    always_comb begin
        if (neg_reg) begin
            sat_val = (div_big || div_quo > 33'h0_8000_0000) ? 32'h8000_0000
                    : 32'(-div_quo);
        end else begin
            sat_val = (div_big || div_quo > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
                    : div_quo[VAL_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= CNT_W'(64);
            cols_reg  <= CNT_W'(64);
            en_reg    <= EN_W'(1);
            zs_reg    <= '0;
            zstep_reg <= STEP_W'(65536);
            xs_reg    <= '0;
            xstep_reg <= STEP_W'(65536);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ROWS:     rows_reg  <= cfg_data[CNT_W-1:0];
                REG_COLS:     cols_reg  <= cfg_data[CNT_W-1:0];
                REG_ENERGIES: en_reg    <= cfg_data[EN_W-1:0];
                REG_Z_START:  zs_reg    <= cfg_data;
                REG_Z_STEP:   zstep_reg <= cfg_data[STEP_W-1:0];
                REG_X_START:  xs_reg    <= cfg_data;
                REG_X_STEP:   xstep_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cap_vld_reg) begin
            f_reg[cap_idx_reg] <= ram_rdata;
        end
        case (state_reg)
            ST_CDIV:  denom_reg <= mul_p[61:0];
            ST_MUL:   p_reg[mul_cnt_reg[1:0]] <= mul_p[63:0];
            ST_SUM: begin
                lower_reg <= p_reg[0] + p_reg[1];
                upper_reg <= p_reg[2] + p_reg[3];
                acc_reg   <= '0;
            end
            ST_MUL2: begin
                pp_reg    <= mul_p;
                pp_hi_reg <= mul_cnt_reg[0];
                if (mul_cnt_reg != 3'd0) begin
                    acc_reg <= acc_reg + (pp_hi_reg ? (pp_ext << 32) : pp_ext);
                end
            end
            ST_MAG: begin
                neg_reg <= acc_reg[ACC_W-1];
                mag_reg <= acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_vld_reg <= 1'b0;
            cap_idx_reg <= '0;
            rd_cnt_reg  <= '0;
            mul_cnt_reg <= '0;
            comp_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
            m_value_reg <= '0;
        end else begin
            cap_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (is_sample) begin
                        comp_reg  <= '0;
                        state_reg <= ST_CDIV;
                    end
                end
                ST_CDIV: begin
                    if (cz_done && cx_done) begin
                        rd_cnt_reg <= '0;
                        if (cz.outside || cx.outside) begin
                            m_valid_reg <= 1'b1;
                            m_value_reg <= '0;
                            m_last_reg  <= (comp_reg == last_comp);
                            state_reg   <= ST_EMIT;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    cap_vld_reg <= 1'b1;
                    cap_idx_reg <= rd_cnt_reg;
                    rd_cnt_reg  <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == 2'd3) begin
                        state_reg <= ST_WAITRD;
                    end
                end
                ST_WAITRD: begin
                    mul_cnt_reg <= '0;
                    state_reg   <= ST_MUL;
                end
                ST_MUL: begin
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == 3'd3) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    mul_cnt_reg <= '0;
                    state_reg   <= ST_MUL2;
                end
                ST_MUL2: begin
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == 3'd4) begin
                        state_reg <= ST_MAG;
                    end
                end
                ST_MAG:    state_reg <= ST_DSTART;
                ST_DSTART: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= sat_val;
                        m_last_reg  <= (comp_reg == last_comp);
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            comp_reg   <= comp_reg + 1'b1;
                            rd_cnt_reg <= '0;
                            if (cz.outside || cx.outside) begin
                                m_valid_reg <= 1'b1;
                                m_value_reg <= '0;
                                m_last_reg  <= (comp_reg + 1'b1 == last_comp);
                            end else begin
                                state_reg <= ST_READ;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_component = comp_reg;
    assign m_out_value     = m_value_reg;
    assign m_last_of_run   = m_last_reg;
endmodule

// File: hw/rtl/gbs_checker.sv
module gbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_mode,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_out_component,
    input logic [31:0] m_out_value,
    input logic        m_last_of_run
);
    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value)
            && $stable(m_out_component) && $stable(m_last_of_run))
        else $error("result beat changed while stalled");

    // no new item while a run is still being delivered
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("input taken in the middle of a run");

    // a run always ends on an imaginary component
    a_last_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_run |-> m_out_component[0])
        else $error("run ended on a real component");

    // a grid write gives no result
    a_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> !m_valid)
        else $error("result after a grid write");
endmodule

bind grid_bilinear_sampler gbs_checker u_gbs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_mode(s_mode), .m_valid(m_valid), .m_ready(m_ready),
    .m_out_component(m_out_component), .m_out_value(m_out_value),
    .m_last_of_run(m_last_of_run)
);

// File: tb/gbs_result_checker.sv
module gbs_result_checker
    import gbs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_mode,
    input  logic [ROW_W-1:0]        s_row_index,
    input  logic [COL_W-1:0]        s_col_index,
    input  logic [COMP_W-1:0]       s_component_index,
    input  logic signed [VAL_W-1:0] s_sample_value,
    input  logic signed [VAL_W-1:0] s_z_coord,
    input  logic signed [VAL_W-1:0] s_x_coord,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [COMP_W-1:0]       m_out_component,
    input  logic signed [VAL_W-1:0] m_out_value,
    input  logic                    m_last_of_run,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [VAL_W-1:0]        cfg_data,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct packed {
        logic [COMP_W-1:0] comp;
        logic [VAL_W-1:0]  value;
        logic              last;
    } blend_beat_t;

    logic [VAL_W-1:0]  grid_mem [0:DEPTH-1];
    logic [CNT_W-1:0]  rows_reg, cols_reg;
    logic [EN_W-1:0]   energies_reg;
    logic [VAL_W-1:0]  z_start_reg, x_start_reg;
    logic [STEP_W-1:0] z_step_reg, x_step_reg;
    blend_beat_t       blend_q[$];

    initial begin
        for (int i = 0; i < DEPTH; i++) grid_mem[i] = '0;
        mismatches = 0;
    end

    assign outstanding = blend_q.size();

    function automatic longint cell_floor(input longint off, input longint step);
        if (off >= 0) return off / step;
        return -((-off + step - 1) / step);
    endfunction

    function automatic void predict_blend(input logic [VAL_W-1:0] zc, input logic [VAL_W-1:0] xc);
        longint nz, nx, dz, dx, offz, offx, iz, ix, rz, rx, base, lower, upper;
        int ncomp;
        bit outside;
        logic signed [127:0] num, lw, up;
        logic [127:0] mag, denom, q;
        blend_beat_t b;
        nz = rows_reg > ROWS_MAX ? ROWS_MAX : rows_reg;
        nx = cols_reg > COLS_MAX ? COLS_MAX : cols_reg;
        ncomp = 2 * (energies_reg < 1 ? 1 : (energies_reg > ENERGIES_MAX ? ENERGIES_MAX
                                                                         : energies_reg));
        dz = z_step_reg == 0 ? 1 : z_step_reg;
        dx = x_step_reg == 0 ? 1 : x_step_reg;
        offz = longint'($signed(zc)) - longint'($signed(z_start_reg));
        offx = longint'($signed(xc)) - longint'($signed(x_start_reg));
        iz = cell_floor(offz, dz);
        ix = cell_floor(offx, dx);
        rz = offz - iz * dz;
        rx = offx - ix * dx;
        outside = iz < 0 || iz + 1 >= nz || ix < 0 || ix + 1 >= nx;
        denom = 128'(dz) * 128'(dx);
        for (int k = 0; k < ncomp; k++) begin
            b.comp = k[COMP_W-1:0];
            b.last = (k == ncomp - 1);
            b.value = '0;
            if (!outside) begin
                base = (iz * COLS_MAX + ix) * COMPS_MAX + k;
                lower = longint'($signed(grid_mem[base])) * (dx - rx)
                      + longint'($signed(grid_mem[base + COMPS_MAX])) * rx;
                upper = longint'($signed(grid_mem[base + COLS_MAX * COMPS_MAX])) * (dx - rx)
                      + longint'($signed(grid_mem[base + COLS_MAX * COMPS_MAX + COMPS_MAX]))
                        * rx;
                lw = lower;
                up = upper;
                num = lw * 128'(dz - rz) + up * 128'(rz);
                mag = num < 0 ? -num : num;
                // round half away from zero on the magnitude
                q = (2 * mag + denom) / (2 * denom);
                if (num < 0) b.value = q > 128'h8000_0000 ? 32'h8000_0000 : -q[31:0];
                else         b.value = q > 128'h7fff_ffff ? 32'h7fff_ffff : q[31:0];
            end
            blend_q.push_back(b);
        end
    endfunction

    always @(posedge aclk) begin
        blend_beat_t e;
        if (!aresetn) begin
            rows_reg     <= 7'd64;
            cols_reg     <= 7'd64;
            energies_reg <= 3'd1;
            z_start_reg  <= '0;
            x_start_reg  <= '0;
            z_step_reg   <= 31'd65536;
            x_step_reg   <= 31'd65536;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_ROWS:     rows_reg     <= cfg_data[CNT_W-1:0];
                    REG_COLS:     cols_reg     <= cfg_data[CNT_W-1:0];
                    REG_ENERGIES: energies_reg <= cfg_data[EN_W-1:0];
                    REG_Z_START:  z_start_reg  <= cfg_data;
                    REG_Z_STEP:   z_step_reg   <= cfg_data[STEP_W-1:0];
                    REG_X_START:  x_start_reg  <= cfg_data;
                    REG_X_STEP:   x_step_reg   <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (!s_mode)
                    grid_mem[(s_row_index * COLS_MAX + s_col_index) * COMPS_MAX
                             + s_component_index] = s_sample_value;
                else
                    predict_blend(s_z_coord, s_x_coord);
            end
            if (m_valid && m_ready) begin
                if (blend_q.size() == 0) begin
                    $display("%0t: unexpected beat comp %0d value %h last %b", $time,
                             m_out_component, m_out_value, m_last_of_run);
                    mismatches++;
                end else begin
                    e = blend_q.pop_front();
                    if (m_out_component !== e.comp) begin
                        $display("%0t: component expected %0d actual %0d", $time, e.comp,
                                 m_out_component);
                        mismatches++;
                    end
                    if (m_out_value !== e.value) begin
                        $display("%0t: value expected %h actual %h", $time, e.value,
                                 m_out_value);
                        mismatches++;
                    end
                    if (m_last_of_run !== e.last) begin
                        $display("%0t: last expected %b actual %b", $time, e.last,
                                 m_last_of_run);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/grid_bilinear_sampler_tb.sv
module grid_bilinear_sampler_tb;
    import gbs_pkg::*;

    logic                    aclk = 0;
    logic                    aresetn;
    logic                    s_valid, s_ready, s_mode;
    logic [ROW_W-1:0]        s_row_index;
    logic [COL_W-1:0]        s_col_index;
    logic [COMP_W-1:0]       s_component_index;
    logic signed [VAL_W-1:0] s_sample_value, s_z_coord, s_x_coord;
    logic                    m_valid, m_ready, m_last_of_run;
    logic [COMP_W-1:0]       m_out_component;
    logic signed [VAL_W-1:0] m_out_value;
    logic                    cfg_valid, cfg_ready;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [VAL_W-1:0]        cfg_data;
    int                      mismatches, outstanding;

    int  send_idle, recv_idle;
    bit  hold_req;
    longint cycles;
    bit  written_map [0:DEPTH-1];
    longint rows_cur, cols_cur, en_cur, zs_cur, zst_cur, xs_cur, xst_cur;

    always #1 aclk = ~aclk;

    grid_bilinear_sampler dut (.*);

    gbs_result_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random backpressure plus one long hold-off on request
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 0;
                repeat (3000) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_beat(input bit mode, input int row, input int col, input int comp,
                             input logic [31:0] val, input logic [31:0] z,
                             input logic [31:0] x);
        logic [ROW_W-1:0]  r;
        logic [COL_W-1:0]  c;
        logic [COMP_W-1:0] k;
        r = row[ROW_W-1:0];
        c = col[COL_W-1:0];
        k = comp[COMP_W-1:0];
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid           <= 1;
        s_mode            <= mode;
        s_row_index       <= r;
        s_col_index       <= c;
        s_component_index <= k;
        s_sample_value    <= val;
        s_z_coord         <= z;
        s_x_coord         <= x;
        if (!mode) written_map[(int'(r) * COLS_MAX + int'(c)) * COMPS_MAX + int'(k)] = 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit find_cell(input logic [31:0] c, input longint st, input longint step,
                                     input longint n, output longint idx);
        longint d, off;
        d = step == 0 ? 1 : step;
        off = longint'($signed(c)) - st;
        idx = off >= 0 ? off / d : -((-off + d - 1) / d);
        return idx >= 0 && idx + 1 < n;
    endfunction

    // loads any missing neighbor entries first, so no unwritten entry is ever read
    task automatic sample_at(input logic [31:0] z, input logic [31:0] x);
        longint iz, ix, nz, nx, nc, a;
        bit in_z, in_x;
        nz = rows_cur > ROWS_MAX ? ROWS_MAX : rows_cur;
        nx = cols_cur > COLS_MAX ? COLS_MAX : cols_cur;
        nc = 2 * (en_cur < 1 ? 1 : (en_cur > ENERGIES_MAX ? ENERGIES_MAX : en_cur));
        in_z = find_cell(z, zs_cur, zst_cur, nz, iz);
        in_x = find_cell(x, xs_cur, xst_cur, nx, ix);
        if (in_z && in_x)
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < 2; c++)
                    for (int k = 0; k < nc; k++) begin
                        a = ((iz + r) * COLS_MAX + ix + c) * COMPS_MAX + k;
                        if (!written_map[a])
                            send_beat(0, iz + r, ix + c, k, rand_word(), $urandom, $urandom);
                    end
        send_beat(1, $urandom, $urandom, $urandom, $urandom, z, x);
    endtask

    function automatic logic [31:0] inside_coord(input longint st, input longint step,
                                                 input longint n);
        longint d, v;
        d = step == 0 ? 1 : step;
        if (n < 2) return $urandom;
        v = st + longint'($urandom_range(n - 2)) * d + longint'($urandom_range(d - 1));
        if (v > 64'sh7fff_ffff || v < -64'sh8000_0000) v = st;
        return v[31:0];
    endfunction

    task automatic random_sample();
        logic [31:0] z, x;
        if ($urandom_range(9) < 7) begin
            z = inside_coord(zs_cur, zst_cur, rows_cur > ROWS_MAX ? ROWS_MAX : rows_cur);
            x = inside_coord(xs_cur, xst_cur, cols_cur > COLS_MAX ? COLS_MAX : cols_cur);
        end else begin
            z = $urandom;
            x = $urandom;
        end
        sample_at(z, x);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        // a trailing grid write may still be in flight
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        cfg_valid <= 1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
        case (idx)
            REG_ROWS:     rows_cur = data[CNT_W-1:0];
            REG_COLS:     cols_cur = data[CNT_W-1:0];
            REG_ENERGIES: en_cur   = data[EN_W-1:0];
            REG_Z_START:  zs_cur   = longint'($signed(data));
            REG_Z_STEP:   zst_cur  = data[STEP_W-1:0];
            REG_X_START:  xs_cur   = longint'($signed(data));
            REG_X_STEP:   xst_cur  = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup_grid(input logic [31:0] rows, input logic [31:0] cols,
                              input logic [31:0] en, input logic [31:0] zs,
                              input logic [31:0] zst, input logic [31:0] xs,
                              input logic [31:0] xst);
        drain();
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_ENERGIES, en);
        write_reg(REG_Z_START, zs);
        write_reg(REG_Z_STEP, zst);
        write_reg(REG_X_START, xs);
        write_reg(REG_X_STEP, xst);
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0; s_mode = 0; s_row_index = 0; s_col_index = 0;
        s_component_index = 0; s_sample_value = 0; s_z_coord = 0; s_x_coord = 0;
        cfg_valid = 0; cfg_addr = 0; cfg_data = 0;
        hold_req = 0; cycles = 0;
        send_idle = 36; recv_idle = 51;
        rows_cur = 64; cols_cur = 64; en_cur = 1;
        zs_cur = 0; zst_cur = 65536; xs_cur = 0; xst_cur = 65536;
        for (int i = 0; i < DEPTH; i++) written_map[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset settings, corners, extremes, outside points
        send_beat(0, 63, 63, 7, 32'h8000_0000, 0, 0);
        send_beat(0, 63, 63, 7, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        sample_at(0, 0);
        sample_at(32'h003e_ffff, 32'h003e_ffff);
        sample_at(32'h0000_8000, 32'h0001_8000);
        sample_at(32'hffff_ffff, 0);
        sample_at(0, 32'h003f_0000);
        sample_at(32'h7fff_ffff, 32'h8000_0000);
        sample_at(32'h8000_0000, 32'h7fff_ffff);

        // smallest grid, most energies, lowest start, unit steps
        setup_grid(2, 2, 4, 32'h8000_0000, 1, 32'h8000_0000, 1);
        sample_at(32'h8000_0000, 32'h8000_0000);
        sample_at(32'h8000_0001, 32'h8000_0000);
        sample_at(32'h7fff_ffff, 32'h8000_0000);
        // widest z step, highest z start
        setup_grid(64, 64, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ff00, 1);
        sample_at(32'h7fff_ffff, 32'hffff_ff05);
        sample_at(32'h7fff_ffff, 32'h0000_003e);
        sample_at(32'h7fff_fffe, 32'hffff_ff05);
        // out-of-range register values: no rows, saturated columns and energies, zero steps
        setup_grid(0, 127, 7, 0, 0, 0, 0);
        sample_at(0, 0);
        setup_grid(1, 64, 0, 0, 32'hffff_ffff, 0, 0);
        sample_at(0, 0);
        setup_grid(127, 127, 7, 0, 0, 0, 0);
        sample_at(0, 0);
        sample_at(5, 62);

        for (int p = 0; p < 3; p++) begin
            setup_grid($urandom_range(8, 2), $urandom_range(8, 2), $urandom_range(4, 1),
                       $urandom_range(2097152) - 1048576, $urandom_range(262144, 1),
                       $urandom_range(2097152) - 1048576, $urandom_range(262144, 1));
            send_idle = p == 0 ? 36 : (p == 1 ? 51 : 0);
            recv_idle = p == 0 ? 51 : (p == 1 ? 36 : 0);
            if (p == 1) begin
                // long receiver hold-off while samples keep coming
                hold_req = 1;
                repeat (6) random_sample();
            end
            for (int i = 0; i < 10; i++) begin
                if ($urandom_range(3) == 0)
                    send_beat(0, $urandom, $urandom, $urandom, rand_word(), $urandom,
                              $urandom);
                else
                    random_sample();
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
